// File: rtl/sorted_priority_queue_core_assert.svh
// Assertion macros for the sorted priority queue core.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH

// check a property on every clock edge outside reset
`define SPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check a property on every clock edge, reset included
`define SPQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/spq_pkg.sv
// Shared types and codes for the sorted priority queue core.
// No dependencies; used by spq_cell and sorted_priority_queue_core.
package spq_pkg;

  localparam int ValueBits = 32;
  localparam int PrioFieldBits = 8;
  localparam int CountFieldBits = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    op_t                           op;
    logic signed [ValueBits-1:0]   value;
    logic [PrioFieldBits-1:0]      priority_req;
  } in_word_t;

  typedef struct packed {
    status_t                       status;
    logic signed [ValueBits-1:0]   removed_value;
    logic signed [ValueBits-1:0]   front_value;
    logic [PrioFieldBits-1:0]      front_priority;
    logic signed [ValueBits-1:0]   rear_value;
    logic [CountFieldBits-1:0]     entry_count;
    logic                          is_empty;
  } out_word_t;

  typedef struct packed {
    logic                          ins;
    logic                          del;
    logic [ValueBits-1:0]          value;
    logic [PrioFieldBits-1:0]      pri;
  } cell_ctrl_t;

endpackage

// File: rtl/spq_cell.sv
// One slot of the sorted shift chain: holds a value and a priority.
// Depends on spq_pkg for the broadcast control word.
module spq_cell #(
  parameter int PW = 8
) (
  input  logic                          clk,
  input  logic                          occ,
  input  spq_pkg::cell_ctrl_t           ctrl,
  input  logic [spq_pkg::ValueBits-1:0] left_val,
  input  logic [PW-1:0]                 left_pri,
  input  logic                          left_gt,
  input  logic [spq_pkg::ValueBits-1:0] right_val,
  input  logic [PW-1:0]                 right_pri,
  output logic [spq_pkg::ValueBits-1:0] val,
  output logic [PW-1:0]                 pri,
  output logic                          gt
);

  logic [spq_pkg::ValueBits-1:0] val_r, val_nxt;
  logic [PW-1:0]                 pri_r, pri_nxt;

  assign gt  = !occ || (pri_r > ctrl.pri[PW-1:0]);
  assign val = val_r;
  assign pri = pri_r;

  always_comb begin
    val_nxt = val_r;
    pri_nxt = pri_r;
    if (ctrl.del) begin
      val_nxt = right_val;
      pri_nxt = right_pri;
    end else if (ctrl.ins) begin
      if (left_gt) begin
        val_nxt = left_val;
        pri_nxt = left_pri;
      end else if (gt) begin
        val_nxt = ctrl.value;
        pri_nxt = ctrl.pri[PW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    pri_r <= pri_nxt;
  end

endmodule

// File: rtl/sorted_priority_queue_core.sv
// Sorted priority queue: a chain of CAPACITY slots kept in priority order.
// Channels: in_valid/in_stall/in_word carry one insert or delete per word;
// out_valid/out_stall/out_word carry one status word per accepted input word.
// Each word reports status, the removed value, the front entry, the rear
// value, the count and an empty flag as they stand after that word.
// All slots compare against the new priority at once and shift by one
// together, so a word is done in the cycle it is accepted and its
// result shows on out_word the next cycle.
// Throughput: one word per cycle while the output is taken; the result
// register holds one word, and a new input word is accepted in the same
// cycle that the held result leaves.
// out_stall high with a result waiting raises in_stall and holds out_word.
// Equal priorities leave in arrival order; inserts into a full queue are
// dropped with a full status, deletes on an empty queue give empty status.
// Reset (rst_n low, synchronous) empties the queue and drops any result.
// Depends on spq_pkg, spq_cell and sorted_priority_queue_core_assert.svh.
`include "sorted_priority_queue_core_assert.svh"

module sorted_priority_queue_core #(
  parameter int CAPACITY      = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  spq_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output spq_pkg::out_word_t out_word
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (PRIORITY_BITS < spq_pkg::PrioFieldBits) ? PRIORITY_BITS
                                                                : spq_pkg::PrioFieldBits;
  localparam int VB = spq_pkg::ValueBits;

  logic                accept, full, empty, ins, del;
  spq_pkg::cell_ctrl_t ctrl;
  logic [VB-1:0]       val_w [CAPACITY];
  logic [PW-1:0]       pri_w [CAPACITY];
  logic [CAPACITY-1:0] gt_w, occ_w;
  logic                tail_ins;

  logic [CW-1:0]          count_r, count_nxt;
  logic                   out_valid_r, out_valid_nxt;
  spq_pkg::status_t       status_r, status_nxt;
  logic [VB-1:0]          removed_r, removed_nxt;
  logic [VB-1:0]          rear_r, rear_nxt;
  logic [CW+spq_pkg::CountFieldBits-1:0] count_ext;
  logic [PW+spq_pkg::PrioFieldBits-1:0]  front_pri_ext;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (count_r == CW'(CAPACITY));
  assign empty    = (count_r == '0);
  assign ins      = accept && (in_word.op == spq_pkg::OP_INSERT) && !full;
  assign del      = accept && (in_word.op == spq_pkg::OP_DELETE) && !empty;

  always_comb begin
    ctrl.ins   = ins;
    ctrl.del   = del;
    ctrl.value = in_word.value;
    ctrl.pri   = in_word.priority_req;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VB-1:0] lv, rv;
    logic [PW-1:0] lp, rp;
    logic          lg;

    assign occ_w[i] = (CW'(i) < count_r);

    if (i == 0) begin : g_head
      assign lv = '0;
      assign lp = '0;
      assign lg = 1'b0;
    end else begin : g_body
      assign lv = val_w[i-1];
      assign lp = pri_w[i-1];
      assign lg = gt_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign rv = '0;
      assign rp = '0;
    end else begin : g_inner
      assign rv = val_w[i+1];
      assign rp = pri_w[i+1];
    end

    spq_cell #(.PW(PW)) u_cell (
      .clk       (clk),
      .occ       (occ_w[i]),
      .ctrl      (ctrl),
      .left_val  (lv),
      .left_pri  (lp),
      .left_gt   (lg),
      .right_val (rv),
      .right_pri (rp),
      .val       (val_w[i]),
      .pri       (pri_w[i]),
      .gt        (gt_w[i])
    );
  end

  // the new entry lands at the rear when no occupied slot holds a larger priority value
  assign tail_ins = ~|(gt_w & occ_w);

  always_comb begin
    count_nxt     = count_r;
    rear_nxt      = rear_r;
    status_nxt    = status_r;
    removed_nxt   = removed_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (accept) begin
      out_valid_nxt = 1'b1;
      removed_nxt   = '0;
      status_nxt    = spq_pkg::ST_DONE;
      if (in_word.op == spq_pkg::OP_INSERT) begin
        if (full) begin
          status_nxt = spq_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
          if (tail_ins) begin
            rear_nxt = in_word.value;
          end
        end
      end else begin
        if (empty) begin
          status_nxt = spq_pkg::ST_EMPTY;
        end else begin
          count_nxt   = count_r - CW'(1);
          removed_nxt = val_w[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    removed_r <= removed_nxt;
    rear_r    <= rear_nxt;
  end

  assign count_ext     = {{spq_pkg::CountFieldBits{1'b0}}, count_r};
  assign front_pri_ext = {{spq_pkg::PrioFieldBits{1'b0}}, pri_w[0]};

  always_comb begin
    out_word.status         = status_r;
    out_word.removed_value  = removed_r;
    out_word.front_value    = empty ? '0 : val_w[0];
    out_word.front_priority = empty ? '0 : front_pri_ext[spq_pkg::PrioFieldBits-1:0];
    out_word.rear_value     = empty ? '0 : rear_r;
    out_word.entry_count    = count_ext[spq_pkg::CountFieldBits-1:0];
    out_word.is_empty       = empty;
  end

  assign out_valid = out_valid_r;

  `SPQ_ASSERT_ALWAYS(a_count_bound, !rst_n || (count_r <= CW'(CAPACITY)),
    "count exceeds capacity")
  `SPQ_ASSERT(a_full_drop, rst_n && accept && (in_word.op == spq_pkg::OP_INSERT) && full |=>
    (status_r == spq_pkg::ST_FULL) && (count_r == CW'(CAPACITY)), "full insert not dropped")
  `SPQ_ASSERT(a_del_count, rst_n && del |=>
    (count_r == $past(count_r) - CW'(1)) && out_valid_r, "delete did not shrink count")
  `SPQ_ASSERT(a_sorted_head, (count_r >= CW'(2)) |-> (pri_w[0] <= pri_w[1]),
    "front slots out of order")

endmodule
